// ----- hdl/sdu_pkg.sv -----
// ----------------------------------------------------------------------------
// sdu_pkg
// shared types, codes and character tables of the data unstuffer
// ----------------------------------------------------------------------------
package sdu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_DOT = 8'h2e;

  localparam logic [31:0] SIZE_LIMIT_RESET = 32'd0;
  localparam logic [31:0] SIZE_LIMIT_ALL   = 32'hffff_ffff;
  localparam logic [31:0] SIZE_LIMIT_CAP   = 32'hffff_fffe;
  localparam logic [7:0]  MAX_HOPS_RESET   = 8'd100;

  // header match columns
  localparam logic [3:0] COL_STOP     = 4'd9;
  localparam logic [3:0] COL_DELIV_LAST = 4'd8;
  localparam logic [3:0] COL_RECV_LAST  = 4'd7;
  localparam logic [3:0] COL_CRLF_LEN   = 4'd2;
  localparam logic [3:0] COL_CRLF_LAST  = 4'd1;

  // match flag bits
  localparam int MF_RECV  = 0;
  localparam int MF_CRLF  = 1;
  localparam int MF_DELIV = 2;

  typedef enum logic [0:0] {
    CFG_SIZE_LIMIT = 1'b0,
    CFG_MAX_HOPS   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HOPS    = 2'd1,
    ST_SIZE    = 2'd2,
    ST_NEWLINE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FS_MID        = 3'd0,
    FS_LINE_START = 3'd1,
    FS_DOT        = 3'd2,
    FS_DOT_CR     = 3'd3,
    FS_CR_HELD    = 3'd4
  } frame_state_t;

  // one accepted byte worth of results, handed from front to back
  typedef struct packed {
    logic [1:0]      num;         // results in this job, 1 to 3
    logic            close;       // single closing result
    status_t         status;
    logic [2:0][7:0] bytes;       // byte results, slot 0 first
    logic [7:0]      hops;
    logic [31:0]     base_count;  // byte count before this job
  } job_t;

  // lower-case letters, compared with bit 5 forced
  function automatic logic [7:0] deliv_char(input logic [3:0] col);
    logic [7:0] c;
    case (col)
      4'd0: c = 8'h64;  // d
      4'd1: c = 8'h65;  // e
      4'd2: c = 8'h6c;  // l
      4'd3: c = 8'h69;  // i
      4'd4: c = 8'h76;  // v
      4'd5: c = 8'h65;  // e
      4'd6: c = 8'h72;  // r
      4'd7: c = 8'h65;  // e
      4'd8: c = 8'h64;  // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] recv_char(input logic [3:0] col);
    logic [7:0] c;
    case (col)
      4'd0: c = 8'h72;  // r
      4'd1: c = 8'h65;  // e
      4'd2: c = 8'h63;  // c
      4'd3: c = 8'h65;  // e
      4'd4: c = 8'h69;  // i
      4'd5: c = 8'h76;  // v
      4'd6: c = 8'h65;  // e
      4'd7: c = 8'h64;  // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    logic [31:0] r;
    if (v == 32'hffff_ffff) begin
      r = v;
    end else begin
      r = v + 32'd1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/sdu_front.sv -----
// ----------------------------------------------------------------------------
// sdu_front
// accepts raw bytes, tracks framing and header lines, builds result jobs
// ----------------------------------------------------------------------------
module sdu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          data_byte,
  input  logic                queue_full,
  input  logic [31:0]         size_limit,
  input  logic [7:0]          max_hops,
  output logic                in_stall,
  output logic                push,
  output sdu_pkg::job_t       job
);

  sdu_pkg::frame_state_t frame_state, frame_state_next;
  logic                  in_header;
  logic [3:0]            line_column;
  logic [2:0]            match_flags;
  logic [7:0]            hop_counter;
  logic [31:0]           emitted_count;

  logic                  hdr_step;
  logic [3:0]            col_step;
  logic [2:0]            mf_step;
  logic [7:0]            hop_step;

  logic                  accept;
  logic [1:0]            nb;
  logic                  close;
  sdu_pkg::status_t      st;
  logic [2:0][7:0]       bytes;
  sdu_pkg::status_t      term_status;
  logic [32:0]           count_sum;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // header line matcher
  always_comb begin
    hdr_step = in_header;
    col_step = line_column;
    mf_step  = match_flags;
    hop_step = hop_counter;
    if (in_header) begin
      if (line_column < sdu_pkg::COL_STOP) begin
        if ((data_byte | 8'h20) != sdu_pkg::deliv_char(line_column)) begin
          mf_step[sdu_pkg::MF_DELIV] = 1'b0;
        end
        if (line_column < sdu_pkg::COL_DELIV_LAST) begin
          if ((data_byte | 8'h20) != sdu_pkg::recv_char(line_column)) begin
            mf_step[sdu_pkg::MF_RECV] = 1'b0;
          end
        end
        if ((mf_step[sdu_pkg::MF_DELIV] && line_column == sdu_pkg::COL_DELIV_LAST) ||
            (mf_step[sdu_pkg::MF_RECV] && line_column == sdu_pkg::COL_RECV_LAST)) begin
          if (hop_counter != 8'hff) begin
            hop_step = hop_counter + 8'd1;
          end
        end
        if (line_column < sdu_pkg::COL_CRLF_LEN) begin
          if (data_byte != ((line_column == 4'd0) ? sdu_pkg::CH_CR : sdu_pkg::CH_LF)) begin
            mf_step[sdu_pkg::MF_CRLF] = 1'b0;
          end
          if (mf_step[sdu_pkg::MF_CRLF] && line_column == sdu_pkg::COL_CRLF_LAST) begin
            hdr_step = 1'b0;
          end
        end
        col_step = line_column + 4'd1;
      end
      if (data_byte == sdu_pkg::CH_LF) begin
        col_step = 4'd0;
        mf_step  = 3'b111;
      end
    end
  end

  // terminator status, hops first
  always_comb begin
    if (hop_step >= max_hops) begin
      term_status = sdu_pkg::ST_HOPS;
    end else if (size_limit != 32'd0 && emitted_count > size_limit) begin
      term_status = sdu_pkg::ST_SIZE;
    end else begin
      term_status = sdu_pkg::ST_OK;
    end
  end

  // next frame state
  always_comb begin
    frame_state_next = sdu_pkg::FS_MID;
    if (data_byte == sdu_pkg::CH_LF) begin
      frame_state_next = sdu_pkg::FS_LINE_START;
    end else begin
      case (frame_state)
        sdu_pkg::FS_LINE_START: begin
          if (data_byte == sdu_pkg::CH_DOT) begin
            frame_state_next = sdu_pkg::FS_DOT;
          end else if (data_byte == sdu_pkg::CH_CR) begin
            frame_state_next = sdu_pkg::FS_CR_HELD;
          end
        end
        sdu_pkg::FS_DOT: begin
          if (data_byte == sdu_pkg::CH_CR) begin
            frame_state_next = sdu_pkg::FS_DOT_CR;
          end
        end
        default: begin
          if (data_byte == sdu_pkg::CH_CR) begin
            frame_state_next = sdu_pkg::FS_CR_HELD;
          end
        end
      endcase
    end
  end

  // results caused by this byte
  always_comb begin
    nb    = 2'd0;
    close = 1'b0;
    st    = sdu_pkg::ST_OK;
    bytes = '0;
    case (frame_state)
      sdu_pkg::FS_LINE_START: begin
        if (data_byte == sdu_pkg::CH_LF) begin
          close = 1'b1;
          st    = sdu_pkg::ST_NEWLINE;
        end else if (data_byte != sdu_pkg::CH_DOT && data_byte != sdu_pkg::CH_CR) begin
          bytes[0] = data_byte;
          nb       = 2'd1;
        end
      end
      sdu_pkg::FS_DOT_CR: begin
        if (data_byte == sdu_pkg::CH_LF) begin
          close = 1'b1;
          st    = term_status;
        end else begin
          bytes[0] = sdu_pkg::CH_DOT;
          bytes[1] = sdu_pkg::CH_CR;
          if (data_byte == sdu_pkg::CH_CR) begin
            nb = 2'd2;
          end else begin
            bytes[2] = data_byte;
            nb       = 2'd3;
          end
        end
      end
      sdu_pkg::FS_CR_HELD: begin
        if (data_byte == sdu_pkg::CH_LF || data_byte == sdu_pkg::CH_CR) begin
          bytes[0] = data_byte;
          nb       = 2'd1;
        end else begin
          bytes[0] = sdu_pkg::CH_CR;
          bytes[1] = data_byte;
          nb       = 2'd2;
        end
      end
      default: begin
        // mid-line and dot at line start behave alike here
        if (data_byte == sdu_pkg::CH_LF) begin
          close = 1'b1;
          st    = sdu_pkg::ST_NEWLINE;
        end else if (data_byte != sdu_pkg::CH_CR) begin
          bytes[0] = data_byte;
          nb       = 2'd1;
        end
      end
    endcase
  end

  assign count_sum = {1'b0, emitted_count} + {31'd0, nb};

  assign push           = accept && (close || nb != 2'd0);
  assign job.num        = close ? 2'd1 : nb;
  assign job.close      = close;
  assign job.status     = st;
  assign job.bytes      = bytes;
  assign job.hops       = hop_step;
  assign job.base_count = emitted_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state   <= sdu_pkg::FS_LINE_START;
      in_header     <= 1'b1;
      line_column   <= 4'd0;
      match_flags   <= 3'b111;
      hop_counter   <= 8'd0;
      emitted_count <= 32'd0;
    end else if (accept) begin
      if (close) begin
        frame_state   <= sdu_pkg::FS_LINE_START;
        in_header     <= 1'b1;
        line_column   <= 4'd0;
        match_flags   <= 3'b111;
        hop_counter   <= 8'd0;
        emitted_count <= 32'd0;
      end else begin
        frame_state   <= frame_state_next;
        in_header     <= hdr_step;
        line_column   <= col_step;
        match_flags   <= mf_step;
        hop_counter   <= hop_step;
        emitted_count <= count_sum[32] ? 32'hffff_ffff : count_sum[31:0];
      end
    end
  end

endmodule

// ----- hdl/sdu_queue.sv -----
// ----------------------------------------------------------------------------
// sdu_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module sdu_queue #(
  parameter int DEPTH = sdu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sdu_pkg::job_t job_in,
  input  logic          pop,
  output sdu_pkg::job_t head,
  output logic          head_valid,
  output logic          full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sdu_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head       = slots[rd_ptr];
  assign head_valid = (fill != '0);
  assign full       = (fill == CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/sdu_back.sv -----
// ----------------------------------------------------------------------------
// sdu_back
// expands queued jobs into one result beat per cycle while out_stall is low, output register
// ----------------------------------------------------------------------------
module sdu_back (
  input  logic          clk,
  input  logic          rst,
  input  sdu_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          last,
  output logic          message_end,
  output logic [1:0]    status,
  output logic [7:0]    hop_count,
  output logic [31:0]   byte_count
);

  logic [1:0]  slot;
  logic [31:0] run_count;
  logic [31:0] cur_count;
  logic [31:0] res_count;
  logic        load;
  logic        is_last;

  assign load      = head_valid && (!out_valid || !out_stall);
  assign is_last   = (slot == head.num - 2'd1);
  assign pop       = load && is_last;
  assign cur_count = (slot == 2'd0) ? head.base_count : run_count;
  assign res_count = head.close ? cur_count : sdu_pkg::sat_inc32(cur_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= is_last ? 2'd0 : slot + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.close ? 8'd0 : head.bytes[slot];
      byte_valid  <= !head.close;
      last        <= is_last;
      message_end <= head.close;
      status      <= head.close ? head.status : sdu_pkg::ST_OK;
      hop_count   <= head.hops;
      byte_count  <= res_count;
      run_count   <= res_count;
    end
  end

endmodule

// ----- hdl/smtp_data_unstuffer.sv -----
// path: an accepted byte's job is written into the job queue, and its first result is then
// loaded from the queue head into the output register
// throughput: one byte accepted per cycle while the job queue has room
// output: one result beat per cycle while not stalled; a dot line that does not end takes up to 3 beats
// reset: framing, header tracking, counters, queue and output valid clear at once
// reset: size_limit goes to 0 (no limit), max_hops to 100
// ----------------------------------------------------------------------------
// smtp_data_unstuffer
// removes dot-stuffing from a mail data stream, folds CR LF to LF, finds the
// end-of-data line, counts hop header lines and reports a closing status
// ----------------------------------------------------------------------------
module smtp_data_unstuffer #(
  parameter int QUEUE_DEPTH = sdu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // raw byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        message_end,
  output logic [1:0]  status,
  output logic [7:0]  hop_count,
  output logic [31:0] byte_count
);

  // policy registers, kept across messages
  logic [31:0]   size_limit;
  logic [7:0]    max_hops;

  // front to queue
  logic          push;
  sdu_pkg::job_t job;
  logic          queue_full;

  // queue to back
  sdu_pkg::job_t head;
  logic          head_valid;
  logic          pop;

  // config port: all ones in size_limit would never trip, store one below
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= sdu_pkg::SIZE_LIMIT_RESET;
      max_hops   <= sdu_pkg::MAX_HOPS_RESET;
    end else if (cfg_we) begin
      case (sdu_pkg::cfg_index_t'(cfg_index))
        sdu_pkg::CFG_SIZE_LIMIT: begin
          size_limit <= (cfg_data == sdu_pkg::SIZE_LIMIT_ALL) ?
                        sdu_pkg::SIZE_LIMIT_CAP : cfg_data;
        end
        sdu_pkg::CFG_MAX_HOPS: begin
          max_hops <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: one byte per cycle while the queue has room, framing and header state, builds a job
  // of zero to three results; zero-result bytes never enter the queue
  sdu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .size_limit (size_limit),
    .max_hops   (max_hops),
    .in_stall   (in_stall),
    .push       (push),
    .job        (job)
  );

  // short queue so the front keeps taking bytes while the back drains a burst
  sdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  // back: walks a job's results one beat at a time into the output register,
  // keeps the running byte count within the job
  sdu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .message_end (message_end),
    .status      (status),
    .hop_count   (hop_count),
    .byte_count  (byte_count)
  );

endmodule

// ----- hdl/sdu_checker.sv -----
// ----------------------------------------------------------------------------
// sdu_checker
// port-level checks on the result stream of the data unstuffer
// ----------------------------------------------------------------------------
module sdu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        last,
  input logic        message_end,
  input logic [1:0]  status,
  input logic [31:0] byte_count
);

  // every beat is either a message byte or the closing beat
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != message_end))
    else $error("beat is neither byte nor close");

  // the closing beat ends the results of its byte
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> last)
    else $error("closing beat not last");

  // byte beats carry ok status and a counted byte
  a_byte_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> (status == sdu_pkg::ST_OK) && (byte_count != 32'd0))
    else $error("byte beat with status or zero count");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(byte_count) && $stable(message_end))
    else $error("stalled beat changed");

endmodule

bind smtp_data_unstuffer sdu_checker u_checker (.*);
